/* hdl/aabb_pkg.sv */
`default_nettype none
package aabb_pkg;

    // Fraction bits of every fixed-point value
    localparam int FRAC_BITS = 16;

    // Widths of the datapath
    localparam int IW  = 32;                   // input and output values
    localparam int HW  = 31;                   // half extents
    localparam int CW  = IW + 2;               // corner component
    localparam int PW  = IW + CW;              // entry times corner
    localparam int VW  = PW - FRAC_BITS + 2;   // row sum
    localparam int QW  = 32;                   // quotient bits
    localparam int RW  = VW + QW;              // divider remainder
    localparam int NLANE = 3;

    // Register file
    localparam int NREG    = 8;
    localparam int ADDR_W  = 6;
    localparam int DATA_W  = 64;

    localparam logic [DATA_W-1:0] ONE_LO = DATA_W'(64'd1 << FRAC_BITS);
    localparam logic [DATA_W-1:0] ONE_HI = DATA_W'(64'd1 << (FRAC_BITS + 32));

    localparam logic signed [IW-1:0] Q_HI = 32'sh7fffffff;
    localparam logic signed [IW-1:0] Q_LO = 32'sh80000000;

    // One lane of the divider pipeline
    typedef struct packed {
        logic [RW-1:0] rem;
        logic [VW-1:0] ad;
        logic [QW-1:0] q;
        logic          neg;
        logic          nneg;
        logic          nzero;
        logic          dzero;
        logic          ovf;
    } div_lane_t;

    // Control bits that travel with a corner
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } tag_t;

endpackage
`default_nettype wire

/* hdl/aabb_matrix_transform.sv */
`default_nettype none
// Box through a 4x4 projective matrix, fixed point.
// Input channel (in_valid/in_ready): a box as center_* and half_*.
// Output channel (out_valid/out_ready): the bounding box of the eight
// projected corners as out_center_*, out_half_* and w_zero_fault.
// Configuration: APB write/read of the eight 64-bit matrix registers at
// byte address 8*i; pready is always high. Reset loads the identity.
// Each box is expanded into eight corners, one per cycle when not stalled,
// that stream through a shared matrix-vector unit and a 32-stage restoring
// divider pipeline (one quotient bit per stage, three lanes for x, y and z).
// The sequencer accepts the next box while it issues the last corner.
// The whole pipeline advances only when the output register is empty or
// being taken; a stalled receiver freezes every stage, nothing is lost.
// Reset (rst_n, asynchronous) clears all valid bits and the sequencer.
module aabb_matrix_transform (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [aabb_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [aabb_pkg::DATA_W-1:0]   pwdata,
    output logic      [aabb_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [31:0]            center_x,
    input  wire logic signed [31:0]            center_y,
    input  wire logic signed [31:0]            center_z,
    input  wire logic [30:0]                   half_x,
    input  wire logic [30:0]                   half_y,
    input  wire logic [30:0]                   half_z,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [31:0]                 out_center_x,
    output logic signed [31:0]                 out_center_y,
    output logic signed [31:0]                 out_center_z,
    output logic [30:0]                        out_half_x,
    output logic [30:0]                        out_half_y,
    output logic [30:0]                        out_half_z,
    output logic                               w_zero_fault
);
    import aabb_pkg::*;

    logic [DATA_W-1:0] mreg_reg [NREG];
    logic adv;

    // Register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mreg_reg[0] <= ONE_LO;
            mreg_reg[1] <= '0;
            mreg_reg[2] <= ONE_HI;
            mreg_reg[3] <= '0;
            mreg_reg[4] <= '0;
            mreg_reg[5] <= ONE_LO;
            mreg_reg[6] <= '0;
            mreg_reg[7] <= ONE_HI;
        end
        else if (psel && penable && pwrite && pready)
        begin
            mreg_reg[paddr[ADDR_W-1:3]] <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = mreg_reg[paddr[ADDR_W-1:3]];

    function automatic logic signed [IW-1:0] ent(input int r, input int c);
        logic [DATA_W-1:0] w;
        w = mreg_reg[r * 2 + c / 2];
        return (c % 2 == 1) ? $signed(w[63:32]) : $signed(w[31:0]);
    endfunction

    // Stall everything while a result waits
    assign adv = !out_valid || out_ready;

    // Corner sequencer
    logic                   busy_reg;
    logic [2:0]             cnt_reg;
    logic signed [IW-1:0]   ctr_reg  [NLANE];
    logic [HW-1:0]          half_reg [NLANE];
    logic                   accept;

    assign in_ready = adv && (!busy_reg || cnt_reg == 3'd7);
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (adv)
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg  <= cnt_reg + 3'd1;
                busy_reg <= (cnt_reg != 3'd7);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ctr_reg[0]  <= center_x;
            ctr_reg[1]  <= center_y;
            ctr_reg[2]  <= center_z;
            half_reg[0] <= half_x;
            half_reg[1] <= half_y;
            half_reg[2] <= half_z;
        end
    end

    // Stage 1: corner
    tag_t                 s1_reg;
    logic signed [CW-1:0] s1_p_reg [NLANE];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_reg <= '0;
        else if (adv)
        begin
            s1_reg.vld   <= busy_reg;
            s1_reg.first <= (cnt_reg == 3'd0);
            s1_reg.last  <= (cnt_reg == 3'd7);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int a = 0; a < NLANE; a++)
            begin
                if (cnt_reg[a])
                    s1_p_reg[a] <= CW'(ctr_reg[a]) + $signed(CW'({1'b0, half_reg[a]}));
                else
                    s1_p_reg[a] <= CW'(ctr_reg[a]) - $signed(CW'({1'b0, half_reg[a]}));
            end
        end
    end

    // Stage 2: products
    tag_t                 s2_reg;
    logic signed [PW-1:0] s2_prod_reg [4][NLANE];
    logic signed [IW-1:0] s2_e3_reg   [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_reg <= '0;
        else if (adv)
            s2_reg <= s1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 4; r++)
            begin
                s2_e3_reg[r] <= ent(r, 3);
                for (int a = 0; a < NLANE; a++)
                    s2_prod_reg[r][a] <= ent(r, a) * s1_p_reg[a];
            end
        end
    end

    // Stage 3: row sums, products floored by the fraction bits
    tag_t                 s3_reg;
    logic signed [VW-1:0] s3_v_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_reg <= '0;
        else if (adv)
            s3_reg <= s2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 4; r++)
                s3_v_reg[r] <= VW'(s2_e3_reg[r])
                             + VW'(s2_prod_reg[r][0] >>> FRAC_BITS)
                             + VW'(s2_prod_reg[r][1] >>> FRAC_BITS)
                             + VW'(s2_prod_reg[r][2] >>> FRAC_BITS);
        end
    end

    // Divider: stage 0 takes magnitudes, stages 1..QW each settle one bit
    tag_t      dv_tag_reg [QW+1];
    div_lane_t dv_reg     [QW+1][NLANE];
    div_lane_t dv_prep    [NLANE];
    div_lane_t dv_step    [QW][NLANE];
    logic [VW-1:0] dmag;

    always_comb
    begin
        dmag = s3_v_reg[3][VW-1] ? VW'(-s3_v_reg[3]) : VW'(s3_v_reg[3]);
        for (int a = 0; a < NLANE; a++)
        begin
            dv_prep[a].nneg  = s3_v_reg[a][VW-1];
            dv_prep[a].nzero = (s3_v_reg[a] == '0);
            dv_prep[a].dzero = (s3_v_reg[3] == '0);
            dv_prep[a].neg   = s3_v_reg[a][VW-1] ^ s3_v_reg[3][VW-1];
            dv_prep[a].ad    = dmag;
            dv_prep[a].q     = '0;
            dv_prep[a].rem   = RW'(s3_v_reg[a][VW-1] ? VW'(-s3_v_reg[a])
                                                      : VW'(s3_v_reg[a])) << FRAC_BITS;
            dv_prep[a].ovf   = dv_prep[a].rem >= (RW'(dmag) << QW);
        end
    end

    // Subtract the shifted divisor where it fits
    always_comb
    begin
        for (int i = 0; i < QW; i++)
        begin
            for (int a = 0; a < NLANE; a++)
            begin
                dv_step[i][a] = dv_reg[i][a];
                if (dv_reg[i][a].rem >= (RW'(dv_reg[i][a].ad) << (QW - 1 - i)))
                begin
                    dv_step[i][a].rem          = dv_reg[i][a].rem
                                               - (RW'(dv_reg[i][a].ad) << (QW - 1 - i));
                    dv_step[i][a].q[QW - 1 - i] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= QW; i++)
                dv_tag_reg[i] <= '0;
        end
        else if (adv)
        begin
            dv_tag_reg[0] <= s3_reg;
            for (int i = 0; i < QW; i++)
                dv_tag_reg[i+1] <= dv_tag_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_reg[0] <= dv_prep;
            for (int i = 0; i < QW; i++)
                dv_reg[i+1] <= dv_step[i];
        end
    end

    // Quotient sign and saturation
    tag_t                 fin_reg;
    logic signed [IW-1:0] fin_t_reg [NLANE];
    logic                 fin_fz_reg;
    logic signed [IW-1:0] fin_t [NLANE];

    always_comb
    begin
        for (int a = 0; a < NLANE; a++)
        begin
            if (dv_reg[QW][a].dzero)
                fin_t[a] = dv_reg[QW][a].nzero ? '0 : (dv_reg[QW][a].nneg ? Q_LO : Q_HI);
            else if (dv_reg[QW][a].ovf)
                fin_t[a] = dv_reg[QW][a].neg ? Q_LO : Q_HI;
            else if (dv_reg[QW][a].neg)
                fin_t[a] = (dv_reg[QW][a].q > 32'h80000000) ? Q_LO
                                                            : $signed(-dv_reg[QW][a].q);
            else
                fin_t[a] = (dv_reg[QW][a].q > 32'h7fffffff) ? Q_HI
                                                            : $signed(dv_reg[QW][a].q);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fin_reg <= '0;
        else if (adv)
            fin_reg <= dv_tag_reg[QW];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fin_t_reg  <= fin_t;
            fin_fz_reg <= dv_reg[QW][0].dzero;
        end
    end

    // Min and max over the corners of one box
    logic signed [IW-1:0] mn_reg [NLANE];
    logic signed [IW-1:0] mx_reg [NLANE];
    logic                 flt_reg;
    logic signed [IW-1:0] mn_new [NLANE];
    logic signed [IW-1:0] mx_new [NLANE];
    logic                 flt_new;
    logic                 box_vld_reg;
    logic signed [IW-1:0] box_mn_reg [NLANE];
    logic signed [IW-1:0] box_mx_reg [NLANE];
    logic                 box_flt_reg;

    always_comb
    begin
        flt_new = fin_reg.first ? fin_fz_reg : (flt_reg || fin_fz_reg);
        for (int a = 0; a < NLANE; a++)
        begin
            mn_new[a] = (fin_reg.first || fin_t_reg[a] < mn_reg[a]) ? fin_t_reg[a]
                                                                    : mn_reg[a];
            mx_new[a] = (fin_reg.first || fin_t_reg[a] > mx_reg[a]) ? fin_t_reg[a]
                                                                    : mx_reg[a];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            box_vld_reg <= 1'b0;
        else if (adv)
            box_vld_reg <= fin_reg.vld && fin_reg.last;
    end

    always_ff @(posedge clk)
    begin
        if (adv && fin_reg.vld)
        begin
            mn_reg      <= mn_new;
            mx_reg      <= mx_new;
            flt_reg     <= flt_new;
            box_mn_reg  <= mn_new;
            box_mx_reg  <= mx_new;
            box_flt_reg <= flt_new;
        end
    end

    // Output register: center and half extent
    logic                 out_vld_reg;
    logic signed [IW-1:0] oc_reg [NLANE];
    logic [HW-1:0]        oh_reg [NLANE];
    logic                 of_reg;
    logic signed [IW:0]   bsum [NLANE];
    logic signed [IW-1:0] bc   [NLANE];
    logic signed [IW:0]   bh   [NLANE];

    always_comb
    begin
        for (int a = 0; a < NLANE; a++)
        begin
            bsum[a] = (IW+1)'(box_mn_reg[a]) + (IW+1)'(box_mx_reg[a]);
            bc[a]   = bsum[a][IW:1];
            bh[a]   = (IW+1)'(bc[a]) - (IW+1)'(box_mn_reg[a]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= box_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv && box_vld_reg)
        begin
            of_reg <= box_flt_reg;
            for (int a = 0; a < NLANE; a++)
            begin
                oc_reg[a] <= bc[a];
                oh_reg[a] <= (bh[a] > 33'sh07fffffff) ? {HW{1'b1}} : bh[a][HW-1:0];
            end
        end
    end

    assign out_valid    = out_vld_reg;
    assign out_center_x = oc_reg[0];
    assign out_center_y = oc_reg[1];
    assign out_center_z = oc_reg[2];
    assign out_half_x   = oh_reg[0];
    assign out_half_y   = oh_reg[1];
    assign out_half_z   = oh_reg[2];
    assign w_zero_fault = of_reg;

    // Checks
    a_seq_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy_reg && cnt_reg == 3'd0))
        else $error("sequencer did not start on accepted item");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && cnt_reg != 3'd7) |-> !in_ready)
        else $error("input accepted mid box");

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> ($stable(cnt_reg) && $stable(box_vld_reg)))
        else $error("pipeline moved during stall");

    a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
        box_vld_reg |-> (box_mn_reg[0] <= box_mx_reg[0] && box_mn_reg[1] <= box_mx_reg[1]
                         && box_mn_reg[2] <= box_mx_reg[2]))
        else $error("box min above max");

endmodule
`default_nettype wire

/* tb/tb_aabb_matrix_transform.sv */
`default_nettype none
module tb_aabb_matrix_transform;
    timeunit 1ns;
    timeprecision 1ps;
    import aabb_pkg::*;

    localparam int LATENCY     = 46;
    localparam int CYCLE_LIMIT = 900000;
    localparam int N_RANDOM    = 1700;

    // Register indexes of the matrix file
    typedef enum int {
        R0_C01 = 0, R0_C23 = 1, R1_C01 = 2, R1_C23 = 3,
        R2_C01 = 4, R2_C23 = 5, R3_C01 = 6, R3_C23 = 7
    } mreg_idx_e;

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic [30:0]        hx;
        logic [30:0]        hy;
        logic [30:0]        hz;
    } box_t;

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic [30:0]        hx;
        logic [30:0]        hy;
        logic [30:0]        hz;
        logic               fault;
    } bound_t;

    // Directed row: box, and a typed-in bound where obvious
    typedef struct {
        box_t   b;
        bit     known;
        bound_t want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [31:0] center_x = '0, center_y = '0, center_z = '0;
    logic [30:0] half_x = '0, half_y = '0, half_z = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] out_center_x, out_center_y, out_center_z;
    logic [30:0] out_half_x, out_half_y, out_half_z;
    logic w_zero_fault;

    logic [63:0] matrix_regs [8];
    bound_t      pending_bounds [$];
    int          fail_count = 0;
    int          cycle_count = 0;
    bit          rx_enable = 1'b0;

    aabb_matrix_transform dut (.*);

    always #6 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want,
                 cycle_count);
        fail_count++;
    endtask

    function automatic longint mat_entry(int r, int c);
        logic [63:0] w;
        logic [31:0] h;
        w = matrix_regs[r*2 + c/2];
        h = (c % 2) ? w[63:32] : w[31:0];
        return longint'(signed'(h));
    endfunction

    // Floor shift by FRAC_BITS of an exact product (up to 66 bits)
    function automatic longint prod_shift(longint e, longint p);
        logic signed [95:0] full;
        full = 96'(signed'(e)) * 96'(signed'(p));
        return longint'(full >>> FRAC_BITS);
    endfunction

    function automatic longint div_sat(longint n, longint d, inout bit fault);
        logic signed [95:0] num, qq;
        if (d == 0)
        begin
            fault = 1'b1;
            return n > 0 ? 64'sd2147483647 : (n < 0 ? -64'sd2147483648 : 0);
        end
        num = 96'(signed'(n)) <<< FRAC_BITS;
        qq = num / 96'(signed'(d));
        if (qq > 96'sd2147483647) return 64'sd2147483647;
        if (qq < -96'sd2147483648) return -64'sd2147483648;
        return longint'(qq);
    endfunction

    function automatic bound_t project_box(box_t b);
        longint ctr[3], hlf[3], mn[3], mx[3], p[3], v[4], t, c, h, s;
        bit fault;
        bound_t res;
        fault = 1'b0;
        ctr[0] = b.cx; ctr[1] = b.cy; ctr[2] = b.cz;
        hlf[0] = b.hx; hlf[1] = b.hy; hlf[2] = b.hz;
        for (int k = 0; k < 8; k++)
        begin
            for (int a = 0; a < 3; a++)
                p[a] = ((k >> a) & 1) ? ctr[a] + hlf[a] : ctr[a] - hlf[a];
            for (int r = 0; r < 4; r++)
            begin
                s = mat_entry(r, 3);
                for (int a = 0; a < 3; a++)
                    s += prod_shift(mat_entry(r, a), p[a]);
                v[r] = s;
            end
            for (int a = 0; a < 3; a++)
            begin
                t = div_sat(v[a], v[3], fault);
                if (k == 0 || t < mn[a]) mn[a] = t;
                if (k == 0 || t > mx[a]) mx[a] = t;
            end
        end
        for (int a = 0; a < 3; a++)
        begin
            c = (mn[a] + mx[a]) >>> 1;
            h = c - mn[a];
            if (h > 64'sd2147483647) h = 64'sd2147483647;
            case (a)
                0: begin res.cx = c[31:0]; res.hx = h[30:0]; end
                1: begin res.cy = c[31:0]; res.hy = h[30:0]; end
                default: begin res.cz = c[31:0]; res.hz = h[30:0]; end
            endcase
        end
        res.fault = fault;
        return res;
    endfunction

    task automatic write_reg(input mreg_idx_e idx, input logic [63:0] val);
        @(posedge clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= ADDR_W'(idx * 8); pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        matrix_regs[idx] = val;
    endtask

    task automatic load_matrix(input logic [63:0] m [8]);
        for (int i = 0; i < 8; i++)
            write_reg(mreg_idx_e'(i), m[i]);
    endtask

    // Wait until every pending bound has come back, then drain the pipe
    task automatic drain_pipe();
        in_valid <= 1'b0;
        while (pending_bounds.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 50) return 0;
        if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Valid stays high into the next item when there is no gap
    task automatic send_box(input box_t b, input bit known, input bound_t want);
        int gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        center_x <= b.cx; center_y <= b.cy; center_z <= b.cz;
        half_x <= b.hx; half_y <= b.hy; half_z <= b.hz;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_bounds.push_back(known ? want : project_box(b));
    endtask

    function automatic logic [31:0] rand_q();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'($signed($urandom_range(0, 65536*8)) - 65536*4);
            3: return 32'($urandom_range(0, 65536*64)) - 32'(65536*32);
            default: return $urandom;
        endcase
    endfunction

    function automatic box_t rand_box(bit wide);
        box_t b;
        b.cx = rand_q(); b.cy = rand_q(); b.cz = rand_q();
        if (wide)
        begin
            b.hx = $urandom; b.hy = $urandom; b.hz = $urandom;
        end
        else
        begin
            b.hx = $urandom_range(0, 65536*16);
            b.hy = $urandom_range(0, 65536*16);
            b.hz = $urandom_range(0, 65536*16);
        end
        return b;
    endfunction

    // Random matrix: mostly affine-like, sometimes fully random
    task automatic random_matrix(output logic [63:0] m [8]);
        for (int i = 0; i < 8; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                m[i] = {$urandom, $urandom};
            else
                m[i] = {32'($urandom_range(0, 65536*4)) - 32'(65536*2),
                        32'($urandom_range(0, 65536*4)) - 32'(65536*2)};
        end
        if ($urandom_range(0, 2) != 0)
            m[R3_C01] = 64'd0;
        if ($urandom_range(0, 2) != 0)
            m[R3_C23] = {32'($urandom_range(65536/2, 65536*4)), 32'd0};
    endtask

    // Receiver: random stalls, compare against oldest pending bound
    initial
    begin
        bound_t w;
        int hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (pending_bounds.size() == 0)
                    report_mismatch("unexpected item", 0, 0);
                else
                begin
                    w = pending_bounds.pop_front();
                    if (out_center_x !== w.cx) report_mismatch("cx", out_center_x, w.cx);
                    if (out_center_y !== w.cy) report_mismatch("cy", out_center_y, w.cy);
                    if (out_center_z !== w.cz) report_mismatch("cz", out_center_z, w.cz);
                    if (out_half_x !== w.hx) report_mismatch("hx", out_half_x, w.hx);
                    if (out_half_y !== w.hy) report_mismatch("hy", out_half_y, w.hy);
                    if (out_half_z !== w.hz) report_mismatch("hz", out_half_z, w.hz);
                    if (w_zero_fault !== w.fault)
                        report_mismatch("fault", w_zero_fault, w.fault);
                end
            end
            // Hold off for a long stretch now and then
            if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else if (rx_enable && $urandom_range(0, 199) == 0)
            begin
                hold = $urandom_range(20, 80);
                out_ready <= 1'b0;
            end
            else if (rx_enable)
                out_ready <= ($urandom_range(0, 99) < 8) ? 1'b0 :
                             ($urandom_range(0, 99) < 70 || pending_bounds.size() > 4);
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        dir_row_t dir_rows [$];
        dir_row_t row;
        logic [63:0] mat [8];
        box_t b;
        bound_t none;
        int wait_cnt;
        rst_n <= 1'b0;
        none = '0;
        matrix_regs[0] = ONE_LO; matrix_regs[1] = 0;
        matrix_regs[2] = ONE_HI; matrix_regs[3] = 0;
        matrix_regs[4] = 0;      matrix_regs[5] = ONE_LO;
        matrix_regs[6] = 0;      matrix_regs[7] = ONE_HI;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Identity after reset: box passes through unchanged
        row.b = '{32'sd65536, -32'sd131072, 32'sd0, 31'd32768, 31'd0, 31'd65536};
        row.known = 1'b1;
        row.want = '{32'sd65536, -32'sd131072, 32'sd0, 31'd32768, 31'd0, 31'd65536, 1'b0};
        dir_rows.push_back(row);
        row.b = '0; row.want = '0;
        dir_rows.push_back(row);
        // Extremes: predictor checks these
        row.known = 1'b0;
        row.b = '{32'h7fffffff, 32'h80000000, 32'h7fffffff,
                  31'h7fffffff, 31'h7fffffff, 31'h7fffffff};
        dir_rows.push_back(row);
        row.b = '{32'h80000000, 32'h80000000, 32'h80000000, 31'h7fffffff, 31'd0, 31'd1};
        dir_rows.push_back(row);
        row.b = '{32'hffffffff, 32'h00000001, 32'h7fffffff, 31'd1, 31'h40000000, 31'd0};
        dir_rows.push_back(row);
        row.b = '{32'h12345678, 32'hedcba987, 32'h55555555,
                  31'h2aaaaaaa, 31'h55555555, 31'h00ffff00};
        dir_rows.push_back(row);
        foreach (dir_rows[i])
            send_box(dir_rows[i].b, dir_rows[i].known, dir_rows[i].want);
        rx_enable = 1'b1;
        drain_pipe();

        // Zero w everywhere: all rows zero, numerators zero, fault set
        for (int i = 0; i < 8; i++) mat[i] = 64'd0;
        load_matrix(mat);
        send_box('{32'sd1000, 32'sd2000, 32'sd3000, 31'd5, 31'd6, 31'd7}, 1'b1,
                 '{32'sd0, 32'sd0, 32'sd0, 31'd0, 31'd0, 31'd0, 1'b1});
        drain_pipe();
        // Zero w with nonzero numerators: saturated quotients
        mat[R0_C23] = {32'sd65536, 32'd0};
        mat[R1_C23] = {-32'sd65536, 32'd0};
        load_matrix(mat);
        send_box('0, 1'b1, '{32'sh7fffffff, 32'sh80000000, 32'sd0, 31'd0, 31'd0, 31'd0,
                            1'b1});
        drain_pipe();
        // w crossing zero inside the box, and tiny w for quotient overflow
        mat[R0_C01] = {32'd0, 32'sd65536}; mat[R0_C23] = 64'd0;
        mat[R1_C01] = {32'sd65536, 32'd0}; mat[R1_C23] = 64'd0;
        mat[R2_C01] = 64'd0;               mat[R2_C23] = {32'd0, 32'sd65536};
        mat[R3_C01] = {32'd0, 32'sd65536}; mat[R3_C23] = {32'sd1, 32'd0};
        load_matrix(mat);
        send_box('{32'sd0, 32'sd65536, 32'sd0, 31'd65536, 31'd65536, 31'd65536}, 0, none);
        send_box('{32'sd3, 32'h7fff0000, -32'sd5, 31'd0, 31'd0, 31'd0}, 0, none);
        send_box('{32'h80000000, 32'sd12345, 32'sd0, 31'd2, 31'd0, 31'd0}, 0, none);
        drain_pipe();
        // Extreme register values
        for (int i = 0; i < 8; i++) mat[i] = {32'h80000000, 32'h7fffffff};
        load_matrix(mat);
        send_box('{32'h7fffffff, 32'h80000000, 32'sd1, 31'h7fffffff, 31'd1, 31'd0}, 0, none);
        drain_pipe();
        for (int i = 0; i < 8; i++) mat[i] = 64'hffffffff_ffffffff;
        load_matrix(mat);
        send_box('{32'sd65536, 32'sd65536, 32'sd65536, 31'd1, 31'd1, 31'd1}, 0, none);
        drain_pipe();

        // Random phases, new matrix each phase
        for (int ph = 0; ph < 17; ph++)
        begin
            random_matrix(mat);
            load_matrix(mat);
            for (int n = 0; n < N_RANDOM / 17; n++)
            begin
                b = rand_box($urandom_range(0, 9) == 0);
                send_box(b, 1'b0, none);
                // Hold off until every pending bound has come back
                if (n == 40)
                begin
                    in_valid <= 1'b0;
                    while (pending_bounds.size() != 0) @(posedge clk);
                end
            end
            drain_pipe();
        end

        wait_cnt = 0;
        while (pending_bounds.size() != 0 && wait_cnt < 100000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (LATENCY + 8) @(posedge clk);
        if (fail_count == 0 && pending_bounds.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire
